// File: sv/sha512_pkg.sv
`default_nettype none
package sha512_pkg;

	localparam int unsigned WORD_W      = 64;
	localparam int unsigned BLK_WORDS   = 16;
	localparam int unsigned DIG_WORDS   = 8;
	localparam int unsigned ROUNDS      = 80;
	localparam int unsigned LEN_POS     = 112;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef logic [WORD_W-1:0] word_t;

	// one 1024-bit block for the compression unit; word i is words[i]
	typedef struct packed {
		logic [BLK_WORDS-1:0][WORD_W-1:0] words;
		logic                             last_blk;
	} blk_t;

	// queue to core
	typedef struct packed {
		logic avail;
		blk_t blk;
	} q_rd_t;

	function automatic word_t rotr(input word_t x, input int unsigned c);
		rotr = (x >> c) | (x << (WORD_W - c));
	endfunction

	function automatic word_t big_s0(input word_t x);
		big_s0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
	endfunction

	function automatic word_t big_s1(input word_t x);
		big_s1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
	endfunction

	function automatic word_t sml_s0(input word_t x);
		sml_s0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction

	function automatic word_t sml_s1(input word_t x);
		sml_s1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

	function automatic word_t iv_word(input logic [2:0] i);
		case (i)
			3'd0: iv_word = 64'h6a09e667f3bcc908;
			3'd1: iv_word = 64'hbb67ae8584caa73b;
			3'd2: iv_word = 64'h3c6ef372fe94f82b;
			3'd3: iv_word = 64'ha54ff53a5f1d36f1;
			3'd4: iv_word = 64'h510e527fade682d1;
			3'd5: iv_word = 64'h9b05688c2b3e6c1f;
			3'd6: iv_word = 64'h1f83d9abfb41bd6b;
			default: iv_word = 64'h5be0cd19137e2179;
		endcase
	endfunction

	function automatic word_t round_k(input logic [6:0] r);
		case (r)
			7'd0:  round_k = 64'h428a2f98d728ae22;
			7'd1:  round_k = 64'h7137449123ef65cd;
			7'd2:  round_k = 64'hb5c0fbcfec4d3b2f;
			7'd3:  round_k = 64'he9b5dba58189dbbc;
			7'd4:  round_k = 64'h3956c25bf348b538;
			7'd5:  round_k = 64'h59f111f1b605d019;
			7'd6:  round_k = 64'h923f82a4af194f9b;
			7'd7:  round_k = 64'hab1c5ed5da6d8118;
			7'd8:  round_k = 64'hd807aa98a3030242;
			7'd9:  round_k = 64'h12835b0145706fbe;
			7'd10: round_k = 64'h243185be4ee4b28c;
			7'd11: round_k = 64'h550c7dc3d5ffb4e2;
			7'd12: round_k = 64'h72be5d74f27b896f;
			7'd13: round_k = 64'h80deb1fe3b1696b1;
			7'd14: round_k = 64'h9bdc06a725c71235;
			7'd15: round_k = 64'hc19bf174cf692694;
			7'd16: round_k = 64'he49b69c19ef14ad2;
			7'd17: round_k = 64'hefbe4786384f25e3;
			7'd18: round_k = 64'h0fc19dc68b8cd5b5;
			7'd19: round_k = 64'h240ca1cc77ac9c65;
			7'd20: round_k = 64'h2de92c6f592b0275;
			7'd21: round_k = 64'h4a7484aa6ea6e483;
			7'd22: round_k = 64'h5cb0a9dcbd41fbd4;
			7'd23: round_k = 64'h76f988da831153b5;
			7'd24: round_k = 64'h983e5152ee66dfab;
			7'd25: round_k = 64'ha831c66d2db43210;
			7'd26: round_k = 64'hb00327c898fb213f;
			7'd27: round_k = 64'hbf597fc7beef0ee4;
			7'd28: round_k = 64'hc6e00bf33da88fc2;
			7'd29: round_k = 64'hd5a79147930aa725;
			7'd30: round_k = 64'h06ca6351e003826f;
			7'd31: round_k = 64'h142929670a0e6e70;
			7'd32: round_k = 64'h27b70a8546d22ffc;
			7'd33: round_k = 64'h2e1b21385c26c926;
			7'd34: round_k = 64'h4d2c6dfc5ac42aed;
			7'd35: round_k = 64'h53380d139d95b3df;
			7'd36: round_k = 64'h650a73548baf63de;
			7'd37: round_k = 64'h766a0abb3c77b2a8;
			7'd38: round_k = 64'h81c2c92e47edaee6;
			7'd39: round_k = 64'h92722c851482353b;
			7'd40: round_k = 64'ha2bfe8a14cf10364;
			7'd41: round_k = 64'ha81a664bbc423001;
			7'd42: round_k = 64'hc24b8b70d0f89791;
			7'd43: round_k = 64'hc76c51a30654be30;
			7'd44: round_k = 64'hd192e819d6ef5218;
			7'd45: round_k = 64'hd69906245565a910;
			7'd46: round_k = 64'hf40e35855771202a;
			7'd47: round_k = 64'h106aa07032bbd1b8;
			7'd48: round_k = 64'h19a4c116b8d2d0c8;
			7'd49: round_k = 64'h1e376c085141ab53;
			7'd50: round_k = 64'h2748774cdf8eeb99;
			7'd51: round_k = 64'h34b0bcb5e19b48a8;
			7'd52: round_k = 64'h391c0cb3c5c95a63;
			7'd53: round_k = 64'h4ed8aa4ae3418acb;
			7'd54: round_k = 64'h5b9cca4f7763e373;
			7'd55: round_k = 64'h682e6ff3d6b2b8a3;
			7'd56: round_k = 64'h748f82ee5defb2fc;
			7'd57: round_k = 64'h78a5636f43172f60;
			7'd58: round_k = 64'h84c87814a1f0ab72;
			7'd59: round_k = 64'h8cc702081a6439ec;
			7'd60: round_k = 64'h90befffa23631e28;
			7'd61: round_k = 64'ha4506cebde82bde9;
			7'd62: round_k = 64'hbef9a3f7b2c67915;
			7'd63: round_k = 64'hc67178f2e372532b;
			7'd64: round_k = 64'hca273eceea26619c;
			7'd65: round_k = 64'hd186b8c721c0c207;
			7'd66: round_k = 64'heada7dd6cde0eb1e;
			7'd67: round_k = 64'hf57d4f7fee6ed178;
			7'd68: round_k = 64'h06f067aa72176fba;
			7'd69: round_k = 64'h0a637dc5a2c898a6;
			7'd70: round_k = 64'h113f9804bef90dae;
			7'd71: round_k = 64'h1b710b35131c471b;
			7'd72: round_k = 64'h28db77f523047d84;
			7'd73: round_k = 64'h32caab7b40c72493;
			7'd74: round_k = 64'h3c9ebe0a15c9bebc;
			7'd75: round_k = 64'h431d67c49c100d4c;
			7'd76: round_k = 64'h4cc5d4becb3e42b6;
			7'd77: round_k = 64'h597f299cfc657e2a;
			7'd78: round_k = 64'h5fcb6fab3ad6faec;
			7'd79: round_k = 64'h6c44198c4a475817;
			default: round_k = '0;
		endcase
	endfunction

endpackage
`default_nettype wire

// File: sv/sha512_message_hash.sv
// SHA-512 over a byte stream. Each item carries at most one message byte
// (byte_present) and may close the message (end_of_message); an item that
// closes the message without a byte pads only what was already taken, so a
// lone closing item hashes the empty message. The front end takes one byte
// per cycle, when not stalled, into a 128-byte buffer and hands each full
// block to a two-block queue; padding and the length field cost one or two
// further block hand-offs. Input is stalled during every hand-off and for
// as long as the queue is full. The compression core loads each block,
// runs 80 rounds and then a feed-forward, so over a long message the
// sustained rate is set by the front end's byte-per-cycle fill plus its
// hand-off; the core keeps up. After the last block, the eight digest words
// come out word 0 first, one per cycle when not stalled, with digest_last
// on word 7, and the chaining state returns to the standard initial values
// for the next message. The core pops no new block until the last digest
// word has been loaded into the output register.
`default_nettype none
module sha512_message_hash import sha512_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_present,
	input  wire logic        end_of_message,
	output logic             digest_valid,
	input  wire logic        digest_stall,
	output logic [63:0]      digest_word,
	output logic             digest_last
);

	// front end -> queue
	logic  q_push;
	logic  q_full;
	blk_t  q_blk;
	// queue -> core
	q_rd_t q_rd;
	logic  q_pop;

	sha512_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.data_byte      (data_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_blk          (q_blk)
	);

	sha512_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_blk (q_blk),
		.full     (q_full),
		.pop      (q_pop),
		.rd       (q_rd)
	);

	// round unit, chaining words and digest output register
	sha512_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd           (q_rd),
		.pop          (q_pop),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest_word  (digest_word),
		.digest_last  (digest_last)
	);

endmodule
`default_nettype wire

// File: sv/sha512_front.sv
`default_nettype none
module sha512_front import sha512_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       byte_present,
	input  wire logic       end_of_message,
	input  wire logic       q_full,
	output logic            q_push,
	output blk_t            q_blk
);

	typedef enum logic [3:0] {
		F_TAKE = 4'b0001,
		F_FULL = 4'b0010,
		F_PAD  = 4'b0100,
		F_LEN  = 4'b1000
	} fstate_t;

	fstate_t                          state_q;
	logic [6:0]                       fill_q;
	logic [63:0]                      count_q;
	logic                             end_q;
	logic [BLK_WORDS-1:0][WORD_W-1:0] buf_q;
	logic [BLK_WORDS-1:0][WORD_W-1:0] padded;
	logic                             take;
	word_t                            len_hi, len_lo;

	assign byte_stall = (state_q != F_TAKE);
	assign take       = byte_valid && (state_q == F_TAKE);
	assign len_hi     = {61'd0, count_q[63:61]};
	assign len_lo     = {count_q[60:0], 3'd0};
	assign q_push     = (state_q != F_TAKE) && !q_full;

	always_comb begin
		padded = buf_q;
		padded[fill_q[6:3]][{~fill_q[2:0], 3'b000} +: 8] = PAD_BYTE;
		q_blk = '0;
		case (state_q)
			F_FULL: begin
				q_blk.words = buf_q;
			end
			F_PAD: begin
				q_blk.words = padded;
				if (fill_q < 7'(LEN_POS)) begin
					q_blk.words[14] = len_hi;
					q_blk.words[15] = len_lo;
					q_blk.last_blk  = 1'b1;
				end
			end
			F_LEN: begin
				q_blk.words[14] = len_hi;
				q_blk.words[15] = len_lo;
				q_blk.last_blk  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_TAKE;
			fill_q  <= '0;
			count_q <= '0;
			end_q   <= 1'b0;
			buf_q   <= '0;
		end else begin
			case (state_q)
				F_TAKE: begin
					if (take) begin
						if (byte_present) begin
							buf_q[fill_q[6:3]][{~fill_q[2:0], 3'b000} +: 8] <= data_byte;
							fill_q  <= fill_q + 7'd1;
							count_q <= count_q + 64'd1;
						end
						end_q <= end_of_message;
						if (byte_present && fill_q == 7'd127) begin
							state_q <= F_FULL;
						end else if (end_of_message) begin
							state_q <= F_PAD;
						end
					end
				end
				F_FULL: begin
					if (q_push) begin
						buf_q   <= '0;
						state_q <= end_q ? F_PAD : F_TAKE;
					end
				end
				F_PAD: begin
					if (q_push) begin
						buf_q <= '0;
						if (fill_q < 7'(LEN_POS)) begin
							fill_q  <= '0;
							count_q <= '0;
							state_q <= F_TAKE;
						end else begin
							state_q <= F_LEN;
						end
					end
				end
				F_LEN: begin
					if (q_push) begin
						fill_q  <= '0;
						count_q <= '0;
						state_q <= F_TAKE;
					end
				end
				default: state_q <= F_TAKE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: sv/sha512_queue.sv
`default_nettype none
module sha512_queue import sha512_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  blk_t      push_blk,
	output logic      full,
	input  wire logic pop,
	output q_rd_t     rd
);

	blk_t              ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign rd.avail = (cnt_q != '0);
	assign rd.blk   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wr_q] <= push_blk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop && rd.avail) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push && !full) - QCNT_W'(pop && rd.avail);
		end
	end

endmodule
`default_nettype wire

// File: sv/sha512_core.sv
`default_nettype none
module sha512_core import sha512_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  q_rd_t       rd,
	output logic        pop,
	output logic        digest_valid,
	input  wire logic   digest_stall,
	output logic [63:0] digest_word,
	output logic        digest_last
);

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_RND  = 4'b0010,
		B_FF   = 4'b0100,
		B_OUT  = 4'b1000
	} bstate_t;

	bstate_t    state_q;
	word_t      w_q [BLK_WORDS];
	word_t      a_q [DIG_WORDS];
	word_t      h_q [DIG_WORDS];
	logic [6:0] rnd_q;
	logic       last_q;
	logic [2:0] k_q;
	logic       ov_q;
	word_t      word_q;
	logic       dlast_q;
	word_t      t1, t2, w_next;
	logic       load_out;

	assign digest_valid = ov_q;
	assign digest_word  = word_q;
	assign digest_last  = dlast_q;
	assign pop          = (state_q == B_IDLE) && rd.avail;
	assign load_out     = (state_q == B_OUT) && (!ov_q || !digest_stall);

	// round datapath; the schedule window runs in parallel
	assign t1 = a_q[7] + big_s1(a_q[4]) + ((a_q[4] & a_q[5]) ^ (~a_q[4] & a_q[6]))
		+ round_k(rnd_q) + w_q[0];
	assign t2 = big_s0(a_q[0]) + ((a_q[0] & a_q[1]) ^ (a_q[0] & a_q[2]) ^ (a_q[1] & a_q[2]));
	assign w_next = sml_s1(w_q[14]) + w_q[9] + sml_s0(w_q[1]) + w_q[0];

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < BLK_WORDS; i++) begin
				w_q[i] <= rd.blk.words[i];
			end
			for (int i = 0; i < DIG_WORDS; i++) begin
				a_q[i] <= h_q[i];
			end
		end else if (state_q == B_RND) begin
			for (int i = 0; i < BLK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[BLK_WORDS-1] <= w_next;
			a_q[7] <= a_q[6];
			a_q[6] <= a_q[5];
			a_q[5] <= a_q[4];
			a_q[4] <= a_q[3] + t1;
			a_q[3] <= a_q[2];
			a_q[2] <= a_q[1];
			a_q[1] <= a_q[0];
			a_q[0] <= t1 + t2;
		end
		if (load_out) begin
			word_q  <= h_q[k_q];
			dlast_q <= (k_q == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			rnd_q   <= '0;
			last_q  <= 1'b0;
			k_q     <= '0;
			ov_q    <= 1'b0;
			for (int i = 0; i < DIG_WORDS; i++) begin
				h_q[i] <= iv_word(3'(i));
			end
		end else begin
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (!digest_stall) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						last_q  <= rd.blk.last_blk;
						rnd_q   <= '0;
						state_q <= B_RND;
					end
				end
				B_RND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'(ROUNDS - 1)) begin
						state_q <= B_FF;
					end
				end
				B_FF: begin
					for (int i = 0; i < DIG_WORDS; i++) begin
						h_q[i] <= h_q[i] + a_q[i];
					end
					k_q     <= '0;
					state_q <= last_q ? B_OUT : B_IDLE;
				end
				B_OUT: begin
					if (load_out) begin
						k_q  <= k_q + 3'd1;
						if (k_q == 3'd7) begin
							for (int i = 0; i < DIG_WORDS; i++) begin
								h_q[i] <= iv_word(3'(i));
							end
							state_q <= B_IDLE;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: sv/sha512_checker.sv
`default_nettype none
module sha512_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        byte_valid,
	input wire logic        byte_stall,
	input wire logic        digest_valid,
	input wire logic        digest_stall,
	input wire logic [63:0] digest_word,
	input wire logic        digest_last
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid)
		else $error("input item dropped while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_stall |=> digest_valid && $stable(digest_word)
			&& $stable(digest_last))
		else $error("digest word changed while stalled");

	// within one digest, digest_valid stays high after each taken word but the last
	a_words_run: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_stall && !digest_last |=> digest_valid)
		else $error("gap inside a digest");

	a_one_last: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_stall && digest_last |=> !(digest_valid && digest_last))
		else $error("two last words in a row");

endmodule

bind sha512_message_hash sha512_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_valid   (byte_valid),
	.byte_stall   (byte_stall),
	.digest_valid (digest_valid),
	.digest_stall (digest_stall),
	.digest_word  (digest_word),
	.digest_last  (digest_last)
);
`default_nettype wire

// File: dv/sha512_message_hash_test.sv
`timescale 1ns / 100ps
`default_nettype none
module sha512_message_hash_test;
	import sha512_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  data_byte;
	logic        byte_present;
	logic        end_of_message;
	logic        digest_valid;
	logic        digest_stall;
	logic [63:0] digest_word;
	logic        digest_last;

	sha512_message_hash dut (
		.clk(clk), .arst_n(arst_n),
		.byte_valid(byte_valid), .byte_stall(byte_stall),
		.data_byte(data_byte), .byte_present(byte_present),
		.end_of_message(end_of_message),
		.digest_valid(digest_valid), .digest_stall(digest_stall),
		.digest_word(digest_word), .digest_last(digest_last)
	);

	// one expected digest word
	typedef struct {
		logic [63:0] word;
		logic        last;
	} digest_exp_t;

	digest_exp_t digest_queue[$];
	int          error_count;
	int          hold_cycles;   // long receiver hold-off, counted by the sink

	// hash state mirrored in the bench
	logic [63:0] chain[8];
	logic [63:0] msg_block[16];
	logic [63:0] byte_count;
	int unsigned fill;

	function automatic logic [63:0] ror(input logic [63:0] x, input int unsigned c);
		return (x >> c) | (x << (64 - c));
	endfunction

	function automatic logic [63:0] iv(input int i);
		logic [63:0] t[8];
		t = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
			64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
			64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
		return t[i];
	endfunction

	function automatic logic [63:0] kconst(input int r);
		logic [63:0] t[80];
		t = '{
			64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
			64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
			64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
			64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
			64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
			64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
			64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
			64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
			64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
			64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
			64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
			64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
			64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
			64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
			64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
			64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
			64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
			64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
			64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
			64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
			64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
			64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
			64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
			64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
			64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
			64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
			64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
		return t[r];
	endfunction

	function automatic void reset_hash();
		for (int i = 0; i < 8; i++)
			chain[i] = iv(i);
		for (int i = 0; i < 16; i++)
			msg_block[i] = '0;
		byte_count = '0;
		fill = 0;
	endfunction

	function automatic void place_byte(input int unsigned pos, input logic [7:0] b);
		int unsigned sh;
		sh = (7 - (pos % 8)) * 8;
		msg_block[pos / 8] = (msg_block[pos / 8] & ~(64'hff << sh))
			| (64'(b) << sh);
	endfunction

	// one compression of msg_block into chain; schedule is expanded in place
	function automatic void compress_block();
		logic [63:0] v[8];
		logic [63:0] w2, w15, t1, t2;
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int r = 0; r < 80; r++) begin
			if (r >= 16) begin
				w2  = msg_block[(r - 2) % 16];
				w15 = msg_block[(r - 15) % 16];
				msg_block[r % 16] += (ror(w2, 19) ^ ror(w2, 61) ^ (w2 >> 6))
					+ msg_block[(r - 7) % 16]
					+ (ror(w15, 1) ^ ror(w15, 8) ^ (w15 >> 7));
			end
			t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(r) + msg_block[r % 16];
			t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] += v[i];
	endfunction

	// predict the effect of one accepted item
	function automatic void hash_item(input logic [7:0] b, input logic present,
		input logic eom);
		digest_exp_t e;
		if (present) begin
			place_byte(fill, b);
			byte_count++;
			fill = (fill + 1) % 128;
			if (fill == 0)
				compress_block();
		end
		if (!eom)
			return;
		place_byte(fill, PAD_BYTE);
		for (int unsigned p = fill + 1; p < 128; p++)
			place_byte(p, 8'h00);
		if (fill >= LEN_POS) begin
			compress_block();
			for (int i = 0; i < 16; i++)
				msg_block[i] = '0;
		end
		msg_block[14] = byte_count >> 61;
		msg_block[15] = byte_count << 3;
		compress_block();
		for (int k = 0; k < 8; k++) begin
			e.word = chain[k];
			e.last = (k == 7);
			digest_queue.push_back(e);
		end
		for (int i = 0; i < 8; i++)
			chain[i] = iv(i);
		byte_count = '0;
		fill = 0;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	int idle_mode;   // 0: random gaps, 1: no gaps

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// offer one item and wait for it to be taken; valid drops only for a gap
	task automatic send_item(input logic [7:0] b, input logic present,
		input logic eom);
		int g;
		g = (idle_mode == 0) ? gap_len() : 0;
		if (g != 0) begin
			byte_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		byte_valid     <= 1'b1;
		data_byte      <= b;
		byte_present   <= present;
		end_of_message <= eom;
		do
			@(posedge clk);
		while (byte_stall);
		hash_item(b, present, eom);
	endtask

	task automatic send_message(input int unsigned len, input bit empty_end);
		for (int unsigned i = 0; i < len; i++) begin
			if (!empty_end && i == len - 1)
				send_item(8'($urandom), 1'b1, 1'b1);
			else
				send_item(8'($urandom), 1'b1, 1'b0);
		end
		if (empty_end || len == 0)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic wait_drained();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (digest_queue.size() != 0)
			@(posedge clk);
	endtask

	// result sink: random stall, or none when gaps are off, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digest_stall <= 1'b1;
		end else begin
			if (digest_valid && !digest_stall) begin
				if (digest_queue.size() == 0) begin
					$error("digest word with none expected: %h", digest_word);
					error_count++;
				end else begin
					if (digest_word !== digest_queue[0].word) begin
						$error("digest_word expected %h actual %h",
							digest_queue[0].word, digest_word);
						error_count++;
					end
					if (digest_last !== digest_queue[0].last) begin
						$error("digest_last expected %b actual %b",
							digest_queue[0].last, digest_last);
						error_count++;
					end
					void'(digest_queue.pop_front());
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles  <= hold_cycles - 1;
				digest_stall <= 1'b1;
			end else if (idle_mode == 1) begin
				digest_stall <= 1'b0;
			end else begin
				digest_stall <= (gap_len() != 0);
			end
		end
	end

	// directed: empty message, extreme bytes, both endings
	task automatic test_directed();
		send_item(8'h00, 1'b0, 1'b1);                 // empty message
		send_item(8'h5a, 1'b0, 1'b0);                 // ignored item
		send_item(8'hff, 1'b1, 1'b1);                 // one byte, end with byte
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);                 // end without byte
		send_item(8'haa, 1'b1, 1'b0);
		send_item(8'h55, 1'b1, 1'b1);
		wait_drained();
	endtask

	// length field pushed to a second block, and a full block on the last byte
	task automatic test_block_edges();
		int unsigned lens[2];
		lens = '{112, 128};
		foreach (lens[i])
			send_message(lens[i], bit'(lens[i] % 2));
		wait_drained();
	endtask

	// receiver holds off while sender keeps offering; the queue must fill and stall the input
	task automatic test_backpressure();
		hold_cycles = 2000;
		for (int n = 0; n < 6; n++)
			send_message($urandom_range(0, 12), $urandom_range(0, 1));
		wait_drained();
	endtask

	task automatic test_random();
		int unsigned len;
		for (int n = 0; n < 8; n++) begin
			idle_mode = ($urandom_range(0, 4) == 0);
			len = $urandom_range(0, 12);
			if ($urandom_range(0, 5) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_message(len, $urandom_range(0, 1));
			if ($urandom_range(0, 3) == 0)
				wait_drained();   // sender pauses until all digests are out
		end
		idle_mode = 0;
		wait_drained();
	endtask

	initial begin
		error_count    = 0;
		hold_cycles    = 0;
		idle_mode      = 0;
		arst_n         = 1'b0;
		byte_valid     = 1'b0;
		data_byte      = '0;
		byte_present   = 1'b0;
		end_of_message = 1'b0;
		reset_hash();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_block_edges();
		test_backpressure();
		test_random();
		repeat (200) @(posedge clk);
		if (error_count == 0 && digest_queue.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// File: sha512_message_hash.f
sv/sha512_pkg.sv
sv/sha512_front.sv
sv/sha512_queue.sv
sv/sha512_core.sv
sv/sha512_message_hash.sv
sv/sha512_checker.sv
dv/sha512_message_hash_test.sv
